/* design/vcft_pkg.sv */
// Shared types, constants and register codes of the video chunk frame tracker.
`default_nettype none

package vcft_pkg;

	localparam int MAX_CHUNKS = 256;
	localparam int ROW_BITS   = 8;
	localparam int BIT_W      = $clog2(ROW_BITS);
	localparam int ROWS       = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	localparam logic [7:0]  RST_PKT_TYPE = 8'd1;
	localparam logic [15:0] RST_TIMEOUT  = 16'd3000;
	localparam logic [15:0] RST_WINDOW   = 16'd60;

	typedef enum logic [1:0] {
		CFG_PKT_TYPE = 2'd0,
		CFG_TIMEOUT  = 2'd1,
		CFG_WINDOW   = 2'd2
	} vcft_cfg_idx_t;

	localparam logic CMD_CHUNK = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [7:0]  packet_type;
		logic [31:0] frame_number;
		logic [15:0] chunk_index;
		logic [15:0] chunk_count;
	} vcft_in_t;

	typedef struct packed {
		logic        accepted;
		logic        bad_chunk;
		logic        superseded_valid;
		logic [31:0] superseded_frame;
		logic        completed_valid;
		logic [31:0] completed_frame;
	} vcft_out_t;

	typedef struct packed {
		logic [7:0]  pkt_type;
		logic [15:0] timeout;
		logic [15:0] window;
	} vcft_cfg_t;

	typedef struct packed {
		logic             frame_open;
		logic [31:0]      open_frame;
		logic [15:0]      age;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] map_size;
	} vcft_state_t;

	typedef struct packed {
		logic                wr_en;
		logic                clear_all;
		logic [ROW_BITS-1:0] wdata;
	} vcft_map_ctl_t;

endpackage

`default_nettype wire

/* design/vcft_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module vcft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/vcft_update.sv */
// Per-word frame decision: replacement, range check, bitmap update and completion.
`default_nettype none

module vcft_update import vcft_pkg::*; (
	input  wire vcft_in_t            item,
	input  wire vcft_cfg_t           cfg,
	input  wire vcft_state_t         cur,
	input  wire logic [ROW_BITS-1:0] row_data,
	output      vcft_state_t         nxt,
	output      vcft_map_ctl_t       ctl,
	output      vcft_out_t           res
);

	logic [31:0]         ahead;
	logic                is_chunk;
	logic                timed_out;
	logic                replace;
	logic                open_a;
	logic [31:0]         frame_a;
	logic [CNT_W-1:0]    map_size_a;
	logic                current;
	logic                range_bad;
	logic                good;
	logic                resize;
	logic                cleared;
	logic [ROW_BITS-1:0] base;
	logic [BIT_W-1:0]    bit_sel;
	logic                dup;
	logic [CNT_W-1:0]    total_n;
	logic                complete;

	always_comb begin
		is_chunk   = (item.command == CMD_CHUNK) && (item.packet_type == cfg.pkt_type);
		ahead      = item.frame_number - cur.open_frame;
		timed_out  = cur.age > cfg.timeout;
		replace    = is_chunk && (!cur.frame_open || timed_out ||
			((ahead != 32'd0) && (ahead < {16'd0, cfg.window})));
		open_a     = replace || cur.frame_open;
		frame_a    = replace ? item.frame_number : cur.open_frame;
		map_size_a = replace ? '0 : cur.map_size;
		current    = is_chunk && open_a && (item.frame_number == frame_a);
		range_bad  = (item.chunk_count > 16'(MAX_CHUNKS)) ||
			(item.chunk_index >= item.chunk_count);
		good       = current && !range_bad;
		resize     = good && (16'(map_size_a) != item.chunk_count);
		cleared    = replace || resize;
		base       = cleared ? '0 : row_data;
		bit_sel    = item.chunk_index[BIT_W-1:0];
		dup        = base[bit_sel];
		total_n    = (cleared ? '0 : cur.total) + (dup ? CNT_W'(0) : CNT_W'(1));
		complete   = good && (16'(total_n) == item.chunk_count);

		ctl.wr_en     = good && !complete;
		ctl.clear_all = cleared || complete;
		ctl.wdata     = base | (ROW_BITS'(1) << bit_sel);

		nxt = cur;
		if (item.command == CMD_TICK) begin
			if (cur.frame_open && (cur.age != AGE_MAX)) begin
				nxt.age = cur.age + 16'd1;
			end
		end else begin
			if (replace) begin
				nxt.open_frame = item.frame_number;
				nxt.age        = '0;
			end
			nxt.frame_open = open_a && !complete;
			if (complete) begin
				nxt.total    = '0;
				nxt.map_size = '0;
			end else if (good) begin
				nxt.total    = total_n;
				nxt.map_size = CNT_W'(item.chunk_count);
			end else if (replace) begin
				nxt.total    = '0;
				nxt.map_size = '0;
			end
		end

		res.accepted         = good;
		res.bad_chunk        = current && range_bad;
		res.superseded_valid = replace && cur.frame_open;
		res.superseded_frame = (replace && cur.frame_open) ? cur.open_frame : 32'd0;
		res.completed_valid  = complete;
		res.completed_frame  = complete ? frame_a : 32'd0;
	end

endmodule

`default_nettype wire

/* design/video_chunk_frame_tracker_unit.sv */
// Top level of the video chunk frame tracker: input stage, bitmap RAM, state and output register.
// A word accepted into the input stage (item_s1) is decided there and its result is registered into out_data.
// Throughput: one word per cycle while the output is not stalled; bitmap row read in the cycle of acceptance,
// read-modify-write with forwarding from the write of the word just before.
// Stall on the input follows only from a stalled, full output register.
// Reset (arst_n low) closes the frame, loads register defaults and clears all row valid bits.
`default_nettype none

module video_chunk_frame_tracker_unit import vcft_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire vcft_in_t    in_data,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      vcft_out_t   out_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	vcft_cfg_t           cfg_q;
	vcft_state_t         state_q;
	vcft_state_t         state_nxt;
	vcft_map_ctl_t       ctl;
	vcft_out_t           res;
	logic [ROWS-1:0]     row_vld_q;
	logic [ROWS-1:0]     row_vld_nxt;

	logic                vld_s1;
	vcft_in_t            item_s1;
	logic                fwd_s1;
	logic [ROW_BITS-1:0] fwd_data_s1;

	logic                adv;
	logic                in_accept;
	logic                commit;
	logic                ram_we;
	logic [ROW_AW-1:0]   rd_row;
	logic [ROW_AW-1:0]   wr_row;
	logic [ROW_BITS-1:0] ram_rdata;
	logic [ROW_BITS-1:0] row_data;

	assign adv       = !out_valid || !out_stall;
	assign in_stall  = vld_s1 && !adv;
	assign in_accept = in_valid && !in_stall;
	assign commit    = vld_s1 && adv;
	assign ram_we    = commit && ctl.wr_en;
	assign rd_row    = ROW_AW'(in_data.chunk_index >> BIT_W);
	assign wr_row    = ROW_AW'(item_s1.chunk_index >> BIT_W);

	always_comb begin
		if (!row_vld_q[wr_row]) begin
			row_data = '0;
		end else if (fwd_s1) begin
			row_data = fwd_data_s1;
		end else begin
			row_data = ram_rdata;
		end
	end

	always_comb begin
		row_vld_nxt = ctl.clear_all ? '0 : row_vld_q;
		if (ctl.wr_en) begin
			row_vld_nxt[wr_row] = 1'b1;
		end
	end

	vcft_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_row),
		.wdata(ctl.wdata),
		.re   (in_accept),
		.raddr(rd_row),
		.rdata(ram_rdata)
	);

	vcft_update u_update (
		.item    (item_s1),
		.cfg     (cfg_q),
		.cur     (state_q),
		.row_data(row_data),
		.nxt     (state_nxt),
		.ctl     (ctl),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pkt_type <= RST_PKT_TYPE;
			cfg_q.timeout  <= RST_TIMEOUT;
			cfg_q.window   <= RST_WINDOW;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PKT_TYPE: cfg_q.pkt_type <= cfg_wdata[7:0];
				CFG_TIMEOUT:  cfg_q.timeout  <= cfg_wdata;
				CFG_WINDOW:   cfg_q.window   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_s1    <= 1'b0;
			out_valid <= 1'b0;
			state_q   <= '0;
			row_vld_q <= '0;
		end else begin
			if (in_accept) begin
				vld_s1 <= 1'b1;
				fwd_s1 <= ram_we && (wr_row == rd_row);
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid <= vld_s1;
			end
			if (commit) begin
				state_q   <= state_nxt;
				row_vld_q <= row_vld_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1     <= in_data;
			fwd_data_s1 <= ctl.wdata;
		end
		if (commit) begin
			out_data <= res;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_write_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (vld_s1 && adv && ctl.clear_all == (ctl.clear_all && ctl.wr_en || !ctl.wr_en)))
		else $error("bitmap write outside a commit");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!(out_data.accepted && out_data.bad_chunk) &&
			(!out_data.completed_valid || out_data.accepted)))
		else $error("inconsistent result flags");

	a_complete_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.completed_valid) |=> (!state_q.frame_open && row_vld_q == '0))
		else $error("completed frame left open");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the video chunk frame tracker: predicted results vs. block output.
module tb_top import vcft_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 1350;

	class frame_tracker_scoreboard;
		logic [7:0]          chunk_type;
		logic [15:0]         timeout;
		logic [15:0]         window;
		bit                  frame_open;
		logic [31:0]         open_frame;
		logic [15:0]         age;
		bit [MAX_CHUNKS-1:0] seen;
		int unsigned         seen_total;
		int unsigned         map_size;
		vcft_out_t           expected_q[$];
		int                  errors;

		function new();
			chunk_type = RST_PKT_TYPE;
			timeout    = RST_TIMEOUT;
			window     = RST_WINDOW;
			frame_open = 1'b0;
			open_frame = '0;
			age        = '0;
			seen       = '0;
			seen_total = 0;
			map_size   = 0;
			errors     = 0;
		endfunction

		function void set_reg(vcft_cfg_idx_t idx, logic [15:0] value);
			case (idx)
			CFG_PKT_TYPE: chunk_type = value[7:0];
			CFG_TIMEOUT: timeout = value;
			CFG_WINDOW: window = value;
			default: ;
			endcase
		endfunction

		function void clear_map();
			seen       = '0;
			seen_total = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_word(vcft_in_t w);
			vcft_out_t   r;
			logic [31:0] ahead;
			r = '0;
			if (w.command == CMD_TICK) begin
				if (frame_open && age != AGE_MAX)
					age++;
			end else if (w.packet_type == chunk_type) begin
				ahead = w.frame_number - open_frame;
				if (!frame_open || age > timeout || (ahead != 0 && ahead < {16'h0, window})) begin
					if (frame_open) begin
						r.superseded_valid = 1'b1;
						r.superseded_frame = open_frame;
					end
					frame_open = 1'b1;
					open_frame = w.frame_number;
					age        = '0;
					clear_map();
					map_size   = 0;
				end
				if (frame_open && w.frame_number == open_frame) begin
					if (w.chunk_count > MAX_CHUNKS || w.chunk_index >= w.chunk_count) begin
						r.bad_chunk = 1'b1;
					end else begin
						if (map_size != w.chunk_count) begin
							clear_map();
							map_size = 32'(w.chunk_count);
						end
						if (!seen[w.chunk_index]) begin
							seen[w.chunk_index] = 1'b1;
							seen_total++;
						end
						r.accepted = 1'b1;
						if (seen_total == map_size) begin
							r.completed_valid = 1'b1;
							r.completed_frame = open_frame;
							frame_open = 1'b0;
							clear_map();
							map_size = 0;
						end
					end
				end
			end
			expected_q = {expected_q, r};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(vcft_out_t got);
			vcft_out_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected: %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
			compare_field("bad_chunk", 32'(want.bad_chunk), 32'(got.bad_chunk));
			compare_field("superseded_valid", 32'(want.superseded_valid),
			              32'(got.superseded_valid));
			compare_field("superseded_frame", want.superseded_frame, got.superseded_frame);
			compare_field("completed_valid", 32'(want.completed_valid),
			              32'(got.completed_valid));
			compare_field("completed_frame", want.completed_frame, got.completed_frame);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	vcft_in_t      in_data;
	logic          out_valid;
	logic          out_stall;
	vcft_out_t     out_data;
	logic          cfg_we;
	vcft_cfg_idx_t cfg_index;
	logic [15:0]   cfg_wdata;

	frame_tracker_scoreboard sb;
	int burst_left;
	int words_sent;
	int idle_cycles;

	video_chunk_frame_tracker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drops valid and waits for every expected result; called and returns at a falling edge.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() > 0);
	endtask

	task automatic send_word(input vcft_in_t w);
		int g;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 30);
			if ($urandom_range(0, 29) == 0) begin
				drain();
			end else if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	endtask

	function automatic vcft_in_t random_word();
		vcft_in_t w;
		w.command      = 1'($urandom);
		w.packet_type  = 8'($urandom);
		w.frame_number = $urandom;
		w.chunk_index  = 16'($urandom);
		w.chunk_count  = 16'($urandom);
		return w;
	endfunction

	task automatic send_tick();
		vcft_in_t w;
		w = random_word();
		w.command = CMD_TICK;
		send_word(w);
	endtask

	task automatic drive_chunk(input logic [7:0] pt, input logic [31:0] fn,
	                           input logic [15:0] idx, input logic [15:0] cnt);
		vcft_in_t w;
		w.command      = CMD_CHUNK;
		w.packet_type  = pt;
		w.frame_number = fn;
		w.chunk_index  = idx;
		w.chunk_count  = cnt;
		send_word(w);
	endtask

	task automatic write_one(input vcft_cfg_idx_t idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic program_regs(input logic [7:0] pt, input logic [15:0] to,
	                            input logic [15:0] win);
		drain();
		repeat (4) @(negedge clk);
		write_one(CFG_PKT_TYPE, {8'($urandom), pt});
		write_one(CFG_TIMEOUT, to);
		write_one(CFG_WINDOW, win);
		cfg_we <= 1'b0;
	endtask

	// One frame's chunks in shuffled order, with ticks, noise and broken chunks mixed in.
	task automatic play_frame();
		logic [31:0] fn;
		int cnt, span, stop_at, k, j, t, tmp;
		int order[$];
		span = (sb.window > 1) ? int'(sb.window) - 1 : 1;
		case ($urandom_range(0, 9))
		0: fn = $urandom;
		1: fn = sb.open_frame;
		2: fn = sb.open_frame + span;
		3: fn = sb.open_frame + span + 1;
		4: fn = sb.open_frame - $urandom_range(1, 5);
		default: fn = sb.open_frame + $urandom_range(1, (span < 3) ? span : 3);
		endcase
		t = $urandom_range(0, 49);
		cnt = (t == 0) ? MAX_CHUNKS : (t == 1) ? $urandom_range(100, MAX_CHUNKS - 1) :
		      (t < 8) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		for (k = 0; k < cnt; k++)
			order = {order, k};
		for (k = cnt - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, cnt - 1) : cnt;
		for (k = 0; k < stop_at; k++) begin
			case ($urandom_range(0, 39))
			0, 1, 2, 3: send_tick();
			4: send_word(random_word());
			5: drive_chunk(sb.chunk_type, fn, 16'($urandom_range(cnt, 65535)), 16'(cnt));
			6: drive_chunk(sb.chunk_type, fn, 16'(order[k]), 16'($urandom_range(257, 65535)));
			7: drive_chunk(~sb.chunk_type, fn, 16'(order[k]), 16'(cnt));
			8: drive_chunk(sb.chunk_type, fn, 16'(order[(k > 0) ? k - 1 : 0]), 16'(cnt));
			9: drive_chunk(sb.chunk_type, fn, 16'(order[k]),
			               16'((cnt < MAX_CHUNKS) ? cnt + 1 : cnt - 1));
			default: ;
			endcase
			drive_chunk(sb.chunk_type, fn, 16'(order[k]), 16'(cnt));
		end
	endtask

	initial begin
		int mode, span, run;
		bit hold;
		out_stall = 1'b0;
		run = 0;
		hold = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 6);
				default: begin
					if (run == 0) begin
						hold = !hold;
						run = $urandom_range(1, 12);
					end
					run--;
					out_stall <= hold;
				end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int phase, goal;
		sb = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_PKT_TYPE;
		cfg_wdata   = '0;
		words_sent  = 0;
		burst_left  = $urandom_range(1, 30);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values
		send_tick();
		drive_chunk(8'h00, 32'd5, 16'd0, 16'd1);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd0, 16'd3);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd0, 16'd3);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd1, 16'd4);
		drive_chunk(RST_PKT_TYPE, 32'd99, 16'd2, 16'd4);
		drive_chunk(RST_PKT_TYPE, 32'd160, 16'd2, 16'd4);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd4, 16'd4);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd0, 16'd257);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'd0, 16'd0);
		drive_chunk(RST_PKT_TYPE, 32'd100, 16'hFFFF, 16'hFFFF);
		send_tick();
		drive_chunk(RST_PKT_TYPE, 32'd159, 16'd5, 16'd4);
		drive_chunk(RST_PKT_TYPE, 32'd159, 16'd0, 16'd1);
		drive_chunk(RST_PKT_TYPE, 32'hFFFF_FFF0, 16'd255, 16'd256);
		drive_chunk(RST_PKT_TYPE, 32'd5, 16'd0, 16'd1);
		drive_chunk(RST_PKT_TYPE, 32'd10, 16'd0, 16'd2);
		drive_chunk(8'hFF, 32'd10, 16'd1, 16'd2);
		drive_chunk(RST_PKT_TYPE, 32'd10, 16'd1, 16'd2);

		// age right at the timeout, then timeout one below it
		program_regs(RST_PKT_TYPE, 16'd40, 16'd1);
		drive_chunk(RST_PKT_TYPE, 32'h1234_0000, 16'd0, 16'd2);
		repeat (40) send_tick();
		drive_chunk(RST_PKT_TYPE, 32'h1234_0007, 16'd0, 16'd1);
		program_regs(RST_PKT_TYPE, 16'd39, 16'd1);
		drive_chunk(RST_PKT_TYPE, 32'h1234_0007, 16'd0, 16'd1);

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
			0: program_regs(RST_PKT_TYPE, RST_TIMEOUT, RST_WINDOW);
			1: program_regs(8'hFF, 16'd0, 16'd1);
			2: program_regs(8'h00, 16'hFFFF, 16'hFFFF);
			3: program_regs(8'($urandom), 16'($urandom_range(1, 12)), 16'($urandom_range(2, 6)));
			default: program_regs(8'($urandom), 16'($urandom_range(0, 400)),
			                      16'($urandom_range(1, 200)));
			endcase
			goal = words_sent + RANDOM_WORDS / 5;
			while (words_sent < goal)
				play_frame();
		end

		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
